### rtl/afl_pkg.sv
// Shared constants, types and helpers for the audio FIFO with level meter.
package afl_pkg;

  localparam int RING_DEPTH = 4096;
  localparam int PTR_W      = $clog2(RING_DEPTH);
  localparam int CNT_W      = $clog2(RING_DEPTH + 1);

  localparam int SMP_W      = 16;
  localparam int FILL_W     = 13;
  localparam int MS_W       = 31;
  localparam int ALPHA_W    = 16;
  localparam int COEF_W     = 25;
  localparam int ENV_W      = 40;
  localparam int ENV_FRAC_W = 24;
  localparam int HALF_W     = ENV_W / 2;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 25;

  localparam int S_TDATA_W  = 32;
  localparam int S_TUSER_W  = 1;
  localparam int M_TDATA_W  = 96;
  localparam int M_TUSER_W  = 2;

  localparam logic [COEF_W-1:0] COEF_ONE = COEF_W'(1) << ENV_FRAC_W;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_CHANNEL_MODE  = 2'd0,
    CFG_MS_ALPHA      = 2'd1,
    CFG_ATTACK_COEFF  = 2'd2,
    CFG_RELEASE_COEFF = 2'd3
  } cfg_idx_e;

  typedef enum logic [1:0] {
    MODE_MONO   = 2'd0,
    MODE_STEREO = 2'd1,
    MODE_FIRST  = 2'd2
  } chan_mode_e;

  localparam logic ACT_WRITE = 1'b0;
  localparam logic ACT_READ  = 1'b1;

  typedef struct packed {
    logic accept;
    logic do_err;
    logic do_ms;
    logic do_hi;
    logic do_env;
    logic load_out;
  } afl_cmd_t;

  function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] p);
    next_ptr = (p == PTR_W'(RING_DEPTH - 1)) ? '0 : p + PTR_W'(1);
  endfunction

endpackage

### rtl/afl_ctrl.sv
// Sequencing state machine for the audio FIFO with level meter.
module afl_ctrl
  import afl_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  input  logic     in_action_i,
  input  logic     out_ready_i,
  output logic     in_ready_o,
  output logic     out_valid_o,
  output afl_cmd_t cmd_o
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ERR,
    ST_MS,
    ST_HI,
    ST_ENV,
    ST_DONE
  } state_e;

  state_e state_q;
  logic   out_valid_q;

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;

  always_comb begin
    cmd_o          = '0;
    cmd_o.accept   = in_valid_i && (state_q == ST_IDLE);
    cmd_o.do_err   = (state_q == ST_ERR);
    cmd_o.do_ms    = (state_q == ST_MS);
    cmd_o.do_hi    = (state_q == ST_HI);
    cmd_o.do_env   = (state_q == ST_ENV);
    cmd_o.load_out = (state_q == ST_DONE) && (!out_valid_q || out_ready_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_o.load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (cmd_o.accept) begin
            state_q <= (in_action_i == ACT_WRITE) ? ST_ERR : ST_DONE;
          end
        end
        ST_ERR:  state_q <= ST_MS;
        ST_MS:   state_q <= ST_HI;
        ST_HI:   state_q <= ST_ENV;
        ST_ENV:  state_q <= ST_DONE;
        ST_DONE: begin
          if (cmd_o.load_out) begin
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

endmodule

### rtl/afl_dp.sv
// Datapath: sample ring, configuration, level statistics and result register.
module afl_dp
  import afl_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  afl_cmd_t              cmd_i,
  input  logic                  in_action_i,
  input  logic [S_TDATA_W-1:0]  in_data_i,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  output logic [M_TDATA_W-1:0]  out_data_o,
  output logic [M_TUSER_W-1:0]  out_user_o
);

  logic [1:0]         mode_q;
  logic [ALPHA_W-1:0] alpha_q;
  logic [COEF_W-1:0]  attack_q;
  logic [COEF_W-1:0]  release_q;

  logic [SMP_W-1:0]   ring [RING_DEPTH];
  logic [SMP_W-1:0]   rd_data_q;
  logic [PTR_W-1:0]   wr_ptr_q, rd_ptr_q;
  logic [CNT_W-1:0]   occ_q;

  logic               rd_valid_q, dropped_q;
  logic [SMP_W-1:0]   smp_q;
  logic [SMP_W-1:0]   peak_q;
  logic [MS_W-1:0]    ms_acc_q;
  logic [ENV_W-1:0]   env_q;
  logic [MS_W-1:0]    sq_q;
  logic               up_q;
  logic [ENV_W-1:0]   err_q;
  logic [COEF_W-1:0]  coef_q;
  logic signed [48:0] ms_prod_q;
  logic [44:0]        lo_q, hi_q;

  logic [M_TDATA_W-1:0] out_data_q;
  logic [M_TUSER_W-1:0] out_user_q;

  logic signed [SMP_W-1:0] left, right;
  logic [SMP_W:0]          sum17;
  logic [SMP_W-1:0]        smp_new;
  logic                    is_wr, is_rd, full, empty;
  logic [SMP_W-1:0]        mag;
  logic [31:0]             sq;
  logic [ENV_W-1:0]        target;
  logic                    up;
  logic [COEF_W-1:0]       coef_sel;
  logic signed [31:0]      ms_diff;
  logic signed [48:0]      ms_prod;
  logic signed [48:0]      ms_sum;
  logic [44:0]             lo_d, hi_d;
  logic [64:0]             env_tot;
  logic [ENV_W-1:0]        delta;

  assign left  = in_data_i[SMP_W-1:0];
  assign right = in_data_i[2*SMP_W-1:SMP_W];
  assign sum17 = {left[SMP_W-1], left} + {right[SMP_W-1], right};
  assign smp_new = (mode_q == MODE_STEREO) ? sum17[SMP_W:1] : left;

  assign is_wr = cmd_i.accept && (in_action_i == ACT_WRITE);
  assign is_rd = cmd_i.accept && (in_action_i == ACT_READ);
  assign full  = (occ_q == CNT_W'(RING_DEPTH));
  assign empty = (occ_q == '0);

  assign mag      = smp_q[SMP_W-1] ? (~smp_q + SMP_W'(1)) : smp_q;
  assign sq       = {16'b0, mag} * {16'b0, mag};
  assign target   = {mag, {ENV_FRAC_W{1'b0}}};
  assign up       = (target > env_q);
  assign coef_sel = up ? attack_q : release_q;

  assign ms_diff = $signed({1'b0, sq_q}) - $signed({1'b0, ms_acc_q});
  assign ms_prod = $signed({33'b0, alpha_q}) * $signed({{17{ms_diff[31]}}, ms_diff});
  assign ms_sum  = $signed({2'b0, ms_acc_q, 16'b0}) + ms_prod_q;

  assign lo_d = {20'b0, coef_q} * {25'b0, err_q[HALF_W-1:0]};
  assign hi_d = {20'b0, coef_q} * {25'b0, err_q[ENV_W-1:HALF_W]};

  assign env_tot = {hi_q, {HALF_W{1'b0}}} + {20'b0, lo_q};
  assign delta   = env_tot[ENV_W+ENV_FRAC_W-1:ENV_FRAC_W];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q    <= MODE_MONO;
      alpha_q   <= ALPHA_W'(655);
      attack_q  <= COEF_W'(19010);
      release_q <= COEF_W'(2536);
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_CHANNEL_MODE:  mode_q    <= cfg_data_i[1:0];
        CFG_MS_ALPHA:      alpha_q   <= cfg_data_i[ALPHA_W-1:0];
        CFG_ATTACK_COEFF:  attack_q  <= cfg_data_i[COEF_W-1:0];
        CFG_RELEASE_COEFF: release_q <= cfg_data_i[COEF_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (is_wr) begin
      ring[wr_ptr_q] <= smp_new;
    end
    if (is_rd) begin
      rd_data_q <= ring[rd_ptr_q];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q   <= '0;
      rd_ptr_q   <= '0;
      occ_q      <= '0;
      rd_valid_q <= 1'b0;
      dropped_q  <= 1'b0;
      peak_q     <= '0;
      ms_acc_q   <= '0;
      env_q      <= '0;
    end else begin
      if (is_wr) begin
        wr_ptr_q   <= next_ptr(wr_ptr_q);
        rd_valid_q <= 1'b0;
        dropped_q  <= full;
        if (full) begin
          rd_ptr_q <= next_ptr(rd_ptr_q);
        end else begin
          occ_q <= occ_q + CNT_W'(1);
        end
      end
      if (is_rd) begin
        dropped_q  <= 1'b0;
        rd_valid_q <= !empty;
        if (!empty) begin
          rd_ptr_q <= next_ptr(rd_ptr_q);
          occ_q    <= occ_q - CNT_W'(1);
        end
      end
      if (cmd_i.do_err && (mag > peak_q)) begin
        peak_q <= mag;
      end
      if (cmd_i.do_hi) begin
        ms_acc_q <= ms_sum[MS_W+15:16];
      end
      if (cmd_i.do_env) begin
        env_q <= up_q ? (env_q + delta) : (env_q - delta);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (is_wr) begin
      smp_q <= smp_new;
    end
    if (cmd_i.do_err) begin
      sq_q   <= sq[MS_W-1:0];
      up_q   <= up;
      err_q  <= up ? (target - env_q) : (env_q - target);
      coef_q <= (coef_sel > COEF_ONE) ? COEF_ONE : coef_sel;
    end
    if (cmd_i.do_ms) begin
      ms_prod_q <= ms_prod;
      lo_q      <= lo_d;
    end
    if (cmd_i.do_hi) begin
      hi_q <= hi_d;
    end
    if (cmd_i.load_out) begin
      out_data_q <= {4'b0,
                     env_q[ENV_W-1:ENV_FRAC_W],
                     ms_acc_q,
                     peak_q,
                     FILL_W'(occ_q),
                     rd_valid_q ? rd_data_q : SMP_W'(0)};
      out_user_q <= {dropped_q, rd_valid_q};
    end
  end

  assign out_data_o = out_data_q;
  assign out_user_o = out_user_q;

endmodule

### rtl/audio_fifo_with_level_meter.sv
// Top level of the audio FIFO with level meter.
//
//  channel   direction  payload
//  s_axis    in         tuser: action; tdata: left_sample, right_sample
//  m_axis    out        tuser: read_valid, dropped; tdata: read_sample, fill_level,
//                       peak_level, mean_square, envelope_level
//  cfg       in         cfg_idx_i selects channel_mode/ms_alpha/attack/release
//
// A write item passes through the states ERR, MS, HI, ENV and DONE before a
// new acceptance, a read through DONE alone; the write path is set by the chain
// of level updates (square, mean-square multiply, two envelope partial products,
// envelope add). The ring is a single-port-write, registered-read memory with no
// clearing pass. An output register holds a result while the block goes back to
// take the next item; a stalled result holds the sequencer in its final state.
module audio_fifo_with_level_meter
  import afl_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [S_TDATA_W-1:0]  s_axis_tdata,  // left_sample, right_sample
  input  logic [S_TUSER_W-1:0]  s_axis_tuser,  // action
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [M_TDATA_W-1:0]  m_axis_tdata,  // read_sample, fill_level, peak_level,
                                               // mean_square, envelope_level, zero pad
  output logic [M_TUSER_W-1:0]  m_axis_tuser,  // read_valid, dropped
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  afl_cmd_t cmd;

  afl_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_action_i (s_axis_tuser[0]),
    .out_ready_i (m_axis_tready),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .cmd_o       (cmd)
  );

  afl_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .in_action_i (s_axis_tuser[0]),
    .in_data_i   (s_axis_tdata),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .out_data_o  (m_axis_tdata),
    .out_user_o  (m_axis_tuser)
  );

endmodule

### rtl/afl_checker.sv
// Port-level checks for the audio FIFO with level meter, bound to the top level.
module afl_checker
  import afl_pkg::*;
(
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  m_axis_tvalid,
  input logic                  m_axis_tready,
  input logic [M_TDATA_W-1:0]  m_axis_tdata,
  input logic [M_TUSER_W-1:0]  m_axis_tuser
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed while stalled");

  a_flags_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> !(m_axis_tuser[0] && m_axis_tuser[1]))
    else $error("read_valid and dropped both set");

  a_zero_sample: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tuser[0] |-> m_axis_tdata[15:0] == 16'd0)
    else $error("sample nonzero without read_valid");

  a_fill_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[28:16] <= FILL_W'(RING_DEPTH))
    else $error("fill level above ring depth");

  a_drop_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser[1] |-> m_axis_tdata[28:16] == FILL_W'(RING_DEPTH))
    else $error("drop reported with ring not full");

endmodule

bind audio_fifo_with_level_meter afl_checker u_afl_checker (.*);
